>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, with a disable condition
`define RBPE_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, with a disable condition
`define RBPE_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rbpe_pkg.sv
// shared types and constants for the run-length byte pair encoder
// no dependencies; imported by every module of the block
package rbpe_pkg;

  localparam logic [7:0] MAX_RUN = 8'd255;

  localparam int RES_SLOTS   = 4;
  localparam int SLOT_IDX_W  = $clog2(RES_SLOTS);
  localparam int CNT_W       = $clog2(RES_SLOTS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CODEC_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 1'd1;

  localparam logic MODE_COPY = 1'b0;
  localparam logic MODE_RLE  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] capacity;
  } rbpe_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } rbpe_result_t;

  // all results caused by one item, in order
  typedef struct packed {
    rbpe_result_t [RES_SLOTS-1:0] slot;
    logic [CNT_W-1:0]             count;
  } rbpe_cmd_t;

  localparam rbpe_result_t ERR_RESULT = '{data: 8'd0, last: 1'b1, status: STATUS_OVERFLOW};

endpackage

>>> hw/rtl/rbpe_queue.sv
// short command queue between the front and back parts
// depends on rbpe_pkg
module rbpe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rbpe_pkg::rbpe_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output rbpe_pkg::rbpe_cmd_t head,
  output logic              not_empty
);
  import rbpe_pkg::*;

  rbpe_cmd_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QFILL_W-1:0]  fill;

  assign full      = (fill == QFILL_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= QFILL_W'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= QFILL_W'(fill - 1'b1);
      end
    end
  end

endmodule

>>> hw/rtl/rbpe_front.sv
// front part: takes input items, keeps run and frame state, and works out
// the results of each item as one queue command; depends on rbpe_pkg
module rbpe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [7:0]          data_byte,
  input  logic                is_final,
  input  rbpe_pkg::rbpe_cfg_t cfg,
  input  logic                q_full,
  output logic                push,
  output rbpe_pkg::rbpe_cmd_t cmd
);
  import rbpe_pkg::*;

  logic [7:0]  held_value;
  logic [7:0]  run_length;
  logic        run_open;
  logic [31:0] bytes_written;
  logic        dropping;

  logic [32:0] slack;
  logic        room1, room2, room3, room4;
  logic        extend;
  logic        accept;

  // first part: flush of the run held so far; second: new run, copy or error
  logic        p1_pair, p1_err;
  logic [7:0]  p1_cnt;
  logic        p1_last;
  logic        p2_pair, p2_byte, p2_err;
  logic        all_ok;
  logic [SLOT_IDX_W-1:0] base;
  logic [2:0]  written;

  // headroom left in the frame; negative if capacity was lowered mid-frame
  assign slack = {1'b0, cfg.capacity} - {1'b0, bytes_written};
  assign room1 = !slack[32] && (slack[31:0] >= 32'd1);
  assign room2 = !slack[32] && (slack[31:0] >= 32'd2);
  assign room3 = !slack[32] && (slack[31:0] >= 32'd3);
  assign room4 = !slack[32] && (slack[31:0] >= 32'd4);

  assign extend = run_open && (data_byte == held_value) && (run_length < MAX_RUN);

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    p1_pair = 1'b0;
    p1_err  = 1'b0;
    p1_cnt  = run_length;
    p1_last = 1'b0;
    p2_pair = 1'b0;
    p2_byte = 1'b0;
    p2_err  = 1'b0;
    if (cfg.mode == MODE_RLE) begin
      if (extend) begin
        if (is_final) begin
          p1_cnt  = 8'(run_length + 1'b1);
          p1_last = 1'b1;
          p1_pair = room2;
          p1_err  = !room2;
        end
      end else begin
        if (run_open) begin
          p1_pair = room2;
          p1_err  = !room2;
        end
        if (!p1_err && is_final) begin
          if (run_open ? room4 : room2) begin
            p2_pair = 1'b1;
          end else begin
            p2_err = 1'b1;
          end
        end
      end
    end else begin
      if (run_open) begin
        p1_pair = room2;
        p1_err  = !room2;
      end
      if (!p1_err) begin
        if (run_open ? room3 : room1) begin
          p2_byte = 1'b1;
        end else begin
          p2_err = 1'b1;
        end
      end
    end
    all_ok = !(p1_err || p2_err);
  end

  always_comb begin
    cmd     = '0;
    base    = p1_pair ? SLOT_IDX_W'(2) : '0;
    written = (p1_pair ? 3'd2 : 3'd0) + (p2_pair ? 3'd2 : 3'd0) + (p2_byte ? 3'd1 : 3'd0);
    if (p1_pair) begin
      cmd.slot[0] = '{data: p1_cnt, last: 1'b0, status: STATUS_OK};
      cmd.slot[1] = '{data: held_value, last: p1_last, status: STATUS_OK};
    end
    if (p1_err) begin
      cmd.slot[0] = ERR_RESULT;
    end
    if (p2_pair) begin
      cmd.slot[base] = '{data: 8'd1, last: 1'b0, status: STATUS_OK};
      cmd.slot[SLOT_IDX_W'(base + 1'b1)] = '{data: data_byte, last: 1'b1, status: STATUS_OK};
    end
    if (p2_byte) begin
      cmd.slot[base] = '{data: data_byte, last: is_final, status: STATUS_OK};
    end
    if (p2_err) begin
      cmd.slot[base] = ERR_RESULT;
    end
    cmd.count = CNT_W'(written) + CNT_W'(p1_err) + CNT_W'(p2_err);
  end

  assign push = accept && !dropping && (cmd.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_value    <= '0;
      run_length    <= '0;
      run_open      <= 1'b0;
      bytes_written <= '0;
      dropping      <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        // end of frame
        held_value    <= '0;
        run_length    <= '0;
        run_open      <= 1'b0;
        bytes_written <= '0;
        dropping      <= 1'b0;
      end else if (dropping) begin
        // rest of an aborted frame gives nothing
        dropping      <= 1'b1;
      end else if (!all_ok) begin
        dropping      <= 1'b1;
        run_open      <= 1'b0;
        run_length    <= '0;
        bytes_written <= bytes_written + 32'(written);
      end else begin
        bytes_written <= bytes_written + 32'(written);
        if (cfg.mode == MODE_RLE) begin
          if (extend) begin
            run_length <= 8'(run_length + 1'b1);
          end else begin
            held_value <= data_byte;
            run_length <= 8'd1;
            run_open   <= 1'b1;
          end
        end else begin
          run_open   <= 1'b0;
          run_length <= '0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/rbpe_back.sv
// back part: walks the slots of the head command and drives one result
// a cycle through the output register unless res_ready stalls it; depends on rbpe_pkg
module rbpe_back (
  input  logic                clk,
  input  logic                rst,
  input  rbpe_pkg::rbpe_cmd_t head,
  input  logic                q_not_empty,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                status
);
  import rbpe_pkg::*;

  logic [SLOT_IDX_W-1:0] slot_idx;
  logic                  load;
  logic                  last_slot;
  rbpe_result_t          cur;

  assign load      = q_not_empty && (!res_valid || res_ready);
  assign last_slot = ({1'b0, slot_idx} == CNT_W'(head.count - 1'b1));
  assign pop       = load && last_slot;
  assign cur       = head.slot[slot_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      slot_idx  <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        slot_idx  <= last_slot ? '0 : SLOT_IDX_W'(slot_idx + 1'b1);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= cur.data;
      out_last <= cur.last;
      status   <= cur.status;
    end
  end

endmodule

>>> hw/rtl/rle_byte_pair_encoder.sv
// with the queue empty, an item's first result goes through a queue entry, then the output register
// throughput: one item a cycle in while the queue is not full, one result a cycle out
// unless res_ready holds the output; an item gives 0 to 4 results, alternating run-length bytes two each
// the 4-entry command queue lets the input run ahead of the output register
// reset: clears run and frame state, queue and output valid; codec_mode to
// run-length encoding, out_capacity to all ones
module rle_byte_pair_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           is_final,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  output logic                           status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import rbpe_pkg::*;

  rbpe_cfg_t cfg;
  rbpe_cmd_t push_cmd;
  rbpe_cmd_t head;
  logic      push, pop, q_full, q_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_RLE;
      cfg.capacity <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODEC_MODE:   cfg.mode     <= cfg_data[0];
        REG_OUT_CAPACITY: cfg.capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  rbpe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  rbpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty)
  );

  rbpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_not_empty (q_not_empty),
    .pop         (pop),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .status      (status)
  );

endmodule

>>> hw/rtl/rbpe_checker.sv
// port-level checks on the encoder's result channel, bound to the top level
// depends on rbpe_pkg and assert_macros.svh
`include "assert_macros.svh"

module rbpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       status
);
  import rbpe_pkg::*;

  // a stalled result holds
  `RBPE_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(out_byte) && $stable(out_last) && $stable(status), "stalled result changed")

  // an overflow result is a zero byte that closes the frame
  `RBPE_ASSERT_IMPLY(a_err_form, clk, rst, res_valid && (status == STATUS_OVERFLOW), out_last && (out_byte == 8'd0), "malformed overflow result")

  // reset empties the output register
  `RBPE_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !res_valid, "result valid after reset")

endmodule

bind rle_byte_pair_encoder rbpe_checker u_rbpe_checker (.*);

>>> verif/tb_rle_byte_pair_encoder.sv
// self-checking testbench for rle_byte_pair_encoder: byte frames in, count/value pairs or copied bytes out
// depends on rbpe_pkg and the rle_byte_pair_encoder rtl; the encoder scoreboard lives here too

class rle_pair_scoreboard;
  int errors;
  rbpe_pkg::rbpe_result_t expected_out[$];

  // mirror of the encoder's registers and frame state
  logic        cfg_mode;
  logic [31:0] cfg_capacity;
  logic [7:0]  run_value;
  logic [7:0]  run_count;
  bit          run_held;
  logic [31:0] frame_bytes;
  bit          discarding;

  function new();
    errors = 0;
    cfg_mode = rbpe_pkg::MODE_RLE;
    cfg_capacity = 32'hFFFF_FFFF;
    close_frame();
  endfunction

  function void close_frame();
    run_value = 8'd0;
    run_count = 8'd0;
    run_held = 1'b0;
    frame_bytes = 32'd0;
    discarding = 1'b0;
  endfunction

  function void write_reg(logic [rbpe_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    if (idx == rbpe_pkg::REG_CODEC_MODE) cfg_mode = value[0];
    else cfg_capacity = value;
  endfunction

  function int pending();
    return expected_out.size();
  endfunction

  function void push(logic [7:0] data, logic last, logic st);
    rbpe_pkg::rbpe_result_t r;
    r.data = data;
    r.last = last;
    r.status = st;
    expected_out.push_back(r);
  endfunction

  function bit fits(int unsigned extra);
    return ({1'b0, frame_bytes} + 33'(extra)) <= {1'b0, cfg_capacity};
  endfunction

  // count then value, or the overflow result if the pair does not fit
  function bit emit_pair(bit closing);
    if (!fits(2)) begin
      push(8'd0, 1'b1, rbpe_pkg::STATUS_OVERFLOW);
      return 1'b0;
    end
    push(run_count, 1'b0, rbpe_pkg::STATUS_OK);
    push(run_value, closing, rbpe_pkg::STATUS_OK);
    frame_bytes = frame_bytes + 32'd2;
    run_held = 1'b0;
    run_count = 8'd0;
    return 1'b1;
  endfunction

  function void note_byte(logic [7:0] b, logic fin);
    bit ok;
    ok = 1'b1;
    if (discarding) begin
      if (fin) close_frame();
      return;
    end
    if (cfg_mode == rbpe_pkg::MODE_RLE) begin
      if (run_held && b == run_value && run_count < rbpe_pkg::MAX_RUN) begin
        run_count = run_count + 8'd1;
      end else begin
        if (run_held) ok = emit_pair(1'b0);
        if (ok) begin
          run_value = b;
          run_count = 8'd1;
          run_held = 1'b1;
        end
      end
      if (ok && fin) ok = emit_pair(1'b1);
    end else begin
      // copy mode flushes a run left open by an earlier run-length byte
      if (run_held) ok = emit_pair(1'b0);
      if (ok) begin
        if (fits(1)) begin
          push(b, fin, rbpe_pkg::STATUS_OK);
          frame_bytes = frame_bytes + 32'd1;
        end else begin
          push(8'd0, 1'b1, rbpe_pkg::STATUS_OVERFLOW);
          ok = 1'b0;
        end
      end
    end
    if (fin) begin
      close_frame();
    end else if (!ok) begin
      discarding = 1'b1;
      run_held = 1'b0;
      run_count = 8'd0;
    end
  endfunction

  function void check_out_byte(rbpe_pkg::rbpe_result_t got);
    rbpe_pkg::rbpe_result_t exp;
    if (expected_out.size() == 0) begin
      errors++;
      $display("%0t unexpected item: out_byte %02h out_last %0b status %0b",
               $time, got.data, got.last, got.status);
      return;
    end
    exp = expected_out.pop_front();
    if (got.data !== exp.data) begin
      errors++;
      $display("%0t out_byte: expected %02h, got %02h", $time, exp.data, got.data);
    end
    if (got.last !== exp.last) begin
      errors++;
      $display("%0t out_last: expected %0b, got %0b", $time, exp.last, got.last);
    end
    if (got.status !== exp.status) begin
      errors++;
      $display("%0t status: expected %0b, got %0b", $time, exp.status, got.status);
    end
  endfunction
endclass

module tb_rle_byte_pair_encoder;
  import rbpe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 150;
  localparam int SETTLE      = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [7:0]           data_byte = 8'd0;
  logic                 is_final = 1'b0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last;
  logic                 status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CODEC_MODE;
  logic [31:0]          cfg_data = 32'd0;

  rle_pair_scoreboard sb;
  int  cycle_count = 0;
  int  tx_gap_pct = 20;
  int  rx_stall_pct = 20;
  bit  calm = 1'b0;
  int  hold_requests = 0;
  int  holds_done = 0;

  rle_byte_pair_encoder u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rle_byte_pair_encoder: errors");
      $finish;
    end
  end

  // result side: check, then pick ready for the next cycle
  initial begin
    int stall_left;
    int hold_left;
    rbpe_result_t got;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) begin
        got.data = out_byte;
        got.last = out_last;
        got.status = status;
        sb.check_out_byte(got);
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = $urandom_range(1, 4) - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= b;
    is_final <= fin;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_byte(b, fin);
  endtask

  // stop offering items and let every expected result come out
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input bit do_mode, input logic [31:0] mode_word,
                            input bit do_cap, input logic [31:0] cap);
    if (do_mode) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_CODEC_MODE;
      cfg_data <= mode_word;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(REG_CODEC_MODE, mode_word);
    end
    if (do_cap) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_OUT_CAPACITY;
      cfg_data <= cap;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(REG_OUT_CAPACITY, cap);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_random();
    int which;
    int pick;
    logic mode;
    logic [31:0] cap;
    which = $urandom_range(0, 3);
    mode = ($urandom_range(0, 2) != 0) ? MODE_RLE : MODE_COPY;
    pick = $urandom_range(0, 5);
    case (pick)
      0: cap = 32'd0;
      1: cap = $urandom_range(1, 4);
      2: cap = $urandom_range(5, 30);
      3: cap = 32'hFFFF_FFFF;
      4: cap = $urandom;
      default: cap = $urandom_range(30, 80);
    endcase
    // upper bits of the mode word must be ignored
    set_config(which != 1, {31'($urandom), mode}, which != 0, cap);
  endtask

  task automatic send_random_frame(input int len, input bit closes);
    logic [7:0] b;
    int style;
    style = $urandom_range(0, 2);
    b = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (style == 0) b = 8'($urandom);
        else if ($urandom_range(0, 3) == 0) b = (style == 1) ? (b ^ 8'h01) : 8'($urandom);
      end
      send_byte(b, closes && (i == len - 1));
    end
  endtask

  // frames may run past the end of a phase, so settings change mid-frame too
  task automatic run_phase(input int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
      if (len > budget) begin
        send_random_frame(budget, 1'($urandom_range(0, 1)));
        budget = 0;
      end else begin
        send_random_frame(len, 1'b1);
        budget -= len;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // settings after reset: run-length mode, no capacity limit
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // final byte breaks the run: two pairs from one item
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    // switch to copy with a run still open
    send_byte(8'h77, 1'b0);
    send_byte(8'h77, 1'b0);
    wait_drained();
    set_config(1'b1, {31'h0, MODE_COPY}, 1'b0, 32'd0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    // overflow mid-frame, rest of the frame dropped
    wait_drained();
    set_config(1'b1, {31'h7FFF_FFFF, MODE_RLE}, 1'b1, 32'd3);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b1);
    // overflow on the final byte
    wait_drained();
    set_config(1'b0, 32'd0, 1'b1, 32'd1);
    send_byte(8'h06, 1'b1);
    // zero capacity in copy mode
    wait_drained();
    set_config(1'b1, {31'h0, MODE_COPY}, 1'b1, 32'd0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h0A, 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      case ($urandom_range(0, 2))
        0: tx_gap_pct = 0;
        1: tx_gap_pct = 15;
        default: tx_gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 15;
        default: rx_stall_pct = 40;
      endcase
      if (ph == 0) set_config(1'b1, {31'h0, MODE_RLE}, 1'b1, 32'hFFFF_FFFF);
      else if (ph == 1) set_config(1'b1, {31'h0, MODE_COPY}, 1'b1, 32'hFFFF_FFFE);
      else configure_random();
      run_phase(15);
    end

    // output held off while the input keeps offering alternating bytes
    wait_drained();
    set_config(1'b1, {31'h0, MODE_RLE}, 1'b1, 32'hFFFF_FFFF);
    tx_gap_pct = 0;
    hold_requests++;
    for (int i = 0; i < 24; i++) send_byte((i % 2) ? 8'h3C : 8'hC3, i == 23);

    // one run longer than the largest count
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    for (int i = 0; i < 260; i++) send_byte(8'hC3, i == 259);

    wait_drained();
    configure_random();
    calm = 1'b1;
    run_phase(40);
    wait_drained();

    if (sb.errors == 0) $display("tb_rle_byte_pair_encoder: clean");
    else $display("tb_rle_byte_pair_encoder: errors");
    $finish;
  end

endmodule
